/* rtl/lcdc_pkg.sv */
package lcdc_pkg;

    localparam int LINE_PIXELS = 160;
    localparam int NUM_WORDS   = 18;
    localparam int IDX_W       = 5;
    localparam int COORD_MAX   = 255;
    localparam int POS_MAX     = LINE_PIXELS * COORD_MAX + COORD_MAX;
    localparam int POS_W       = $clog2(POS_MAX + 1);
    localparam int BIT_W       = POS_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;

    localparam logic [IDX_W-1:0] IDX_CON1   = 5'd0;
    localparam logic [IDX_W-1:0] IDX_CON2   = 5'd1;
    localparam logic [IDX_W-1:0] IDX_CON5   = 5'd4;
    localparam logic [IDX_W-1:0] IDX_SADDR1 = 5'd5;
    localparam logic [IDX_W-1:0] IDX_BLUE   = 5'd10;
    localparam logic [IDX_W-1:0] IDX_INTMSK = 5'd15;
    localparam logic [IDX_W-1:0] IDX_LPCSEL = 5'd16;

    localparam logic [31:0] CNT_MASK        = 32'h0ffc_0000;
    localparam logic [31:0] BASE_HI_MASK    = 32'h7fc0_0000;
    localparam logic [31:0] BASE_LO_MASK    = 32'h003f_fffe;
    localparam logic [31:0] WORD_ALIGN_MASK = 32'hffff_fffc;
    localparam logic [31:0] INTMSK_RESET    = 32'h0000_0003;
    localparam logic [31:0] LPCSEL_RESET    = 32'h0000_0004;
    localparam logic [31:0] INVALID_READ    = 32'hffff_ffff;
    localparam logic [31:0] DEPTH_4BPP      = 32'd0;
    localparam logic [31:0] DEPTH_2BPP      = 32'd1;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_PIXEL,
        OP_NONE
    } t_op_kind;

    typedef struct packed {
        t_op_kind         kind;
        logic             idx_valid;
        logic [IDX_W-1:0] reg_index;
        logic [31:0]      write_data;
        logic [POS_W-1:0] pix_pos;
        logic [31:0]      memory_word;
    } t_op;

endpackage

/* rtl/lcd_controller_registers_and_pixel_fetch.sv */
// LCD controller register bank (18 words) with pixel address and gray lookup.
// Each transaction is a register read, a register write, a pixel lookup or (mode 3)
// a no-op, and gives exactly one result, in order. The block takes one transaction
// per clock and returns one result per clock while pop keeps up. Requests are
// decoded and the pixel's linear position is formed on the way in, then wait in a
// two-entry queue; a single execute stage that owns the register bank carries
// out one request per cycle, while pop keeps up, into the output register, which
// sets the rate. Reading word 0 steps its line counter; writes to word 0 keep
// the counter and flag a refresh request when bit 0 toggles. After reset all
// words are zero except the interrupt mask (3) and the pin select (4).
module lcd_controller_registers_and_pixel_fetch (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_mode,
    input  logic [lcdc_pkg::IDX_W-1:0] i_reg_index,
    input  logic [31:0]                i_write_data,
    input  logic [7:0]                 i_pixel_x,
    input  logic [7:0]                 i_pixel_y,
    input  logic [31:0]                i_memory_word,
    output logic                       empty,
    input  logic                       pop,
    output logic [31:0]                o_read_data,
    output logic [31:0]                o_fetch_address,
    output logic [3:0]                 o_gray_level,
    output logic                       o_refresh_request
);
    import lcdc_pkg::*;

    t_op  front_op;
    t_op  queue_op;
    logic queue_valid;
    logic back_take;
    logic out_valid;

    lcdc_front u_front (
        .i_mode        (i_mode),
        .i_reg_index   (i_reg_index),
        .i_write_data  (i_write_data),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_memory_word (i_memory_word),
        .o_op          (front_op)
    );

    lcdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .o_valid (queue_valid),
        .o_op    (queue_op),
        .i_pop   (back_take)
    );

    lcdc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (queue_valid),
        .i_op              (queue_op),
        .o_take            (back_take),
        .o_out_valid       (out_valid),
        .i_out_pop         (pop),
        .o_read_data       (o_read_data),
        .o_fetch_address   (o_fetch_address),
        .o_gray_level      (o_gray_level),
        .o_refresh_request (o_refresh_request)
    );

    assign empty = !out_valid;

endmodule

/* rtl/lcdc_front.sv */
module lcdc_front (
    input  logic [1:0]               i_mode,
    input  logic [lcdc_pkg::IDX_W-1:0] i_reg_index,
    input  logic [31:0]              i_write_data,
    input  logic [7:0]               i_pixel_x,
    input  logic [7:0]               i_pixel_y,
    input  logic [31:0]              i_memory_word,
    output lcdc_pkg::t_op            o_op
);
    import lcdc_pkg::*;

    t_op_kind         kind;
    logic [POS_W-1:0] row_pos;

    always_comb begin
        case (i_mode)
            MODE_READ:  kind = OP_READ;
            MODE_WRITE: kind = OP_WRITE;
            MODE_PIXEL: kind = OP_PIXEL;
            default:    kind = OP_NONE;
        endcase
    end

    // linear pixel position does not depend on register state, so work it out here
    assign row_pos = POS_W'(i_pixel_y) * POS_W'(LINE_PIXELS);

    always_comb begin
        o_op.kind        = kind;
        o_op.idx_valid   = (i_reg_index < IDX_W'(NUM_WORDS));
        o_op.reg_index   = i_reg_index;
        o_op.write_data  = i_write_data;
        o_op.pix_pos     = row_pos + POS_W'(i_pixel_x);
        o_op.memory_word = i_memory_word;
    end

endmodule

/* rtl/lcdc_queue.sv */
module lcdc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lcdc_pkg::t_op i_op,
    output logic          o_full,
    output logic          o_valid,
    output lcdc_pkg::t_op o_op,
    input  logic          i_pop
);
    import lcdc_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

/* rtl/lcdc_back.sv */
module lcdc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lcdc_pkg::t_op i_op,
    output logic          o_take,
    output logic          o_out_valid,
    input  logic          i_out_pop,
    output logic [31:0]   o_read_data,
    output logic [31:0]   o_fetch_address,
    output logic [3:0]    o_gray_level,
    output logic          o_refresh_request
);
    import lcdc_pkg::*;

    logic [31:0]      r_bank [NUM_WORDS];
    logic             r_out_valid;
    logic [31:0]      r_read_data, n_read_data;
    logic [31:0]      r_fetch_address, n_fetch_address;
    logic [3:0]       r_gray_level, n_gray_level;
    logic             r_refresh_request, n_refresh_request;

    logic             take;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      wr_data;
    logic [31:0]      con1;
    logic [9:0]       cnt, n_cnt;
    logic [31:0]      con1_stepped;
    logic [BIT_W-1:0] pos_ext, bit_off;
    logic [31:0]      start_sh, base;
    logic [31:0]      pix_word;
    logic [31:0]      blue_sh;
    logic [3:0]       pix_gray;

    assign take        = i_valid && (!r_out_valid || i_out_pop);
    assign o_take      = take;
    assign o_out_valid = r_out_valid;

    // line counter steps down on each read of word 0, reload from word 1 at zero
    assign con1         = r_bank[IDX_CON1];
    assign cnt          = con1[27:18];
    assign n_cnt        = (cnt != '0) ? cnt - 1'b1 : r_bank[IDX_CON2][23:14];
    assign con1_stepped = {con1[31:28], n_cnt, con1[17:0]};

    assign pos_ext  = BIT_W'(i_op.pix_pos);
    assign start_sh = r_bank[IDX_SADDR1] << 1;
    assign base     = (start_sh & BASE_HI_MASK) | (start_sh & BASE_LO_MASK);

    always_comb begin
        if (r_bank[IDX_CON5] == DEPTH_4BPP) begin
            bit_off = pos_ext << 2;
        end else if (r_bank[IDX_CON5] == DEPTH_2BPP) begin
            bit_off = pos_ext << 1;
        end else begin
            bit_off = pos_ext;
        end
    end

    assign pix_word = i_op.memory_word >> bit_off[4:0];
    assign blue_sh  = r_bank[IDX_BLUE] >> {pix_word[1:0], 2'b00};

    always_comb begin
        if (r_bank[IDX_CON5] == DEPTH_4BPP) begin
            pix_gray = pix_word[3:0];
        end else if (r_bank[IDX_CON5] == DEPTH_2BPP) begin
            pix_gray = blue_sh[3:0];
        end else begin
            pix_gray = {4{pix_word[0]}};
        end
    end

    always_comb begin
        n_read_data       = '0;
        n_fetch_address   = '0;
        n_gray_level      = '0;
        n_refresh_request = 1'b0;
        wr_en             = 1'b0;
        wr_idx            = i_op.reg_index;
        wr_data           = i_op.write_data;
        case (i_op.kind)
            OP_READ: begin
                if (!i_op.idx_valid) begin
                    n_read_data = INVALID_READ;
                end else if (i_op.reg_index == IDX_CON1) begin
                    n_read_data = con1_stepped;
                    wr_en       = 1'b1;
                    wr_data     = con1_stepped;
                end else begin
                    n_read_data = r_bank[i_op.reg_index];
                end
            end
            OP_WRITE: begin
                if (i_op.idx_valid) begin
                    wr_en = 1'b1;
                    if (i_op.reg_index == IDX_CON1) begin
                        n_refresh_request = con1[0] ^ i_op.write_data[0];
                        wr_data = (con1 & CNT_MASK) | (i_op.write_data & ~CNT_MASK);
                    end
                end
            end
            OP_PIXEL: begin
                n_fetch_address = base + (32'(bit_off >> 3) & WORD_ALIGN_MASK);
                n_gray_level    = pix_gray;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_bank[i] <= '0;
            end
            r_bank[IDX_INTMSK] <= INTMSK_RESET;
            r_bank[IDX_LPCSEL] <= LPCSEL_RESET;
        end else if (take && wr_en) begin
            r_bank[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_read_data       <= n_read_data;
            r_fetch_address   <= n_fetch_address;
            r_gray_level      <= n_gray_level;
            r_refresh_request <= n_refresh_request;
        end
    end

    assign o_read_data       = r_read_data;
    assign o_fetch_address   = r_fetch_address;
    assign o_gray_level      = r_gray_level;
    assign o_refresh_request = r_refresh_request;

endmodule
